@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL in this folder.
// No dependencies; pulled in by `include where a module checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CLK(label, clk, rst, !(cond))
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ design/ctir_pkg.sv @@
// Constants, register indexes and the divider step for the color temperature block.
// No dependencies; imported by color_temp_ir_ratio.
package ctir_pkg;

   // channel widths
   localparam int CNT_W = 16;
   localparam int SUM_W = CNT_W + 2;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_TIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_READY = 8'd1;
   localparam logic [7:0] INTEG_TIME_RESET = 8'd255;

   // saturation level
   localparam logic [CNT_W-1:0] DIGITAL_SAT = 16'hFFFF;
   localparam int COUNTS_PER_STEP = 1024;
   localparam logic [8:0] ANALOG_LIMIT = 9'd63;
   localparam logic [8:0] INTEG_STEPS = 9'd256;
   localparam logic [9:0] LEVEL_PER_STEP = 10'(COUNTS_PER_STEP - COUNTS_PER_STEP / 4);

   // ratio scaling
   localparam logic [11:0] CCT_COEF = 12'd3810;
   localparam logic [CNT_W-1:0] CCT_OFFSET = 16'd1391;

   // divider geometry
   localparam int NUM_W = CNT_W + 12;
   localparam int DEN_W = CNT_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = NUM_W / BITS_PER_STAGE;

   typedef logic [DEN_W+NUM_W-1:0] div_word_type;

   // one restoring step: word is {remainder, numerator/quotient shift register}
   function automatic div_word_type div_step(div_word_type word, logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] nq;
      rem = word[DEN_W+NUM_W-1:NUM_W];
      nq = word[NUM_W-1:0];
      trial = {rem, nq[NUM_W-1]};
      diff = trial - {1'b0, den};
      if (!diff[DEN_W]) begin
         return {diff[DEN_W-1:0], nq[NUM_W-2:0], 1'b1};
      end else begin
         return {trial[DEN_W-1:0], nq[NUM_W-2:0], 1'b0};
      end
   endfunction

endpackage

@@ design/color_temp_ir_ratio.sv @@
// Color temperature from one raw red/green/blue/clear word, fully pipelined.
// Depends on ctir_pkg and assert_macros.svh.
//
//   channel   direction  handshake              payload
//   req       in         start & !busy          red/green/blue/clear counts
//   rsp       out        rsp_valid strobe       cct_kelvin
//   csr       in         csr_valid & csr_ready  csr_index, csr_wdata
//
// One word enters per cycle while busy is low; it passes the three front stages, the
// multiplier stage, the divider of 14 stages of two restoring steps each and the output
// register, whose valid bit is the result strobe.
// Reset is synchronous; it clears the valid bits and the output register, sets the
// configuration registers to their reset values, and busy is high for one cycle after
// reset. The receiver cannot stall, so the pipeline never holds and busy is low otherwise.
`include "assert_macros.svh"

module color_temp_ir_ratio
   import ctir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CNT_W-1:0]      req_red_count,
   input  logic [CNT_W-1:0]      req_green_count,
   input  logic [CNT_W-1:0]      req_blue_count,
   input  logic [CNT_W-1:0]      req_clear_count,
   output logic                  rsp_valid,
   output logic [CNT_W-1:0]      rsp_cct_kelvin,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // control and configuration registers
   logic       busy_ff;
   logic [7:0] integ_time_ff;
   logic       sensor_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         integ_time_ff <= INTEG_TIME_RESET;
         sensor_ready_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_index == CSR_INTEG_TIME) begin
            integ_time_ff <= csr_wdata[7:0];
         end
         if (csr_valid && csr_index == CSR_SENSOR_READY) begin
            sensor_ready_ff <= csr_wdata[0];
         end
      end
   end

   assign busy = busy_ff;
   assign csr_ready = 1'b1;

   // saturation level from integration time
   logic [8:0]       integ_steps;
   logic [CNT_W-1:0] sat_level;

   always_comb begin
      integ_steps = INTEG_STEPS - {1'b0, integ_time_ff};
      if (integ_steps > ANALOG_LIMIT) begin
         sat_level = DIGITAL_SAT;
      end else begin
         sat_level = CNT_W'(integ_steps[5:0]) * CNT_W'(LEVEL_PER_STEP);
      end
   end

   // stage 1: capture, channel sum, reject checks
   logic             accept;
   logic             s1_vld_ff;
   logic             s1_bad_ff;
   logic [SUM_W-1:0] s1_sum_ff;
   logic [CNT_W-1:0] s1_red_ff;
   logic [CNT_W-1:0] s1_blue_ff;
   logic [CNT_W-1:0] s1_clear_ff;
   logic             s1_bad_in;

   assign accept = start && !busy_ff;
   assign s1_bad_in = !sensor_ready_ff || (req_clear_count == '0)
                      || (req_clear_count >= sat_level);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_bad_ff <= s1_bad_in;
      s1_sum_ff <= SUM_W'(req_red_count) + SUM_W'(req_green_count) + SUM_W'(req_blue_count);
      s1_red_ff <= req_red_count;
      s1_blue_ff <= req_blue_count;
      s1_clear_ff <= req_clear_count;
   end

   // stage 2: IR estimate, half the excess of the sum over clear
   logic             s2_vld_ff;
   logic             s2_bad_ff;
   logic [CNT_W-1:0] s2_red_ff;
   logic [CNT_W-1:0] s2_blue_ff;
   logic [CNT_W-1:0] s2_ir_ff;
   logic [SUM_W-1:0] s2_excess;
   logic [CNT_W-1:0] s2_ir_in;

   always_comb begin
      s2_excess = s1_sum_ff - SUM_W'(s1_clear_ff);
      if (s1_sum_ff > SUM_W'(s1_clear_ff)) begin
         s2_ir_in = s2_excess[CNT_W:1];
      end else begin
         s2_ir_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_bad_ff <= s1_bad_ff;
      s2_red_ff <= s1_red_ff;
      s2_blue_ff <= s1_blue_ff;
      s2_ir_ff <= s2_ir_in;
   end

   // stage 3: corrected channels, wrapping at 16 bits
   logic             s3_vld_ff;
   logic             s3_bad_ff;
   logic [CNT_W-1:0] s3_red_ff;
   logic [CNT_W-1:0] s3_blue_ff;
   logic [CNT_W-1:0] s3_red_in;

   assign s3_red_in = s2_red_ff - s2_ir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_bad_ff <= s2_bad_ff || (s3_red_in == '0);
      s3_red_ff <= s3_red_in;
      s3_blue_ff <= s2_blue_ff - s2_ir_ff;
   end

   // stage 4 feeds divider slot 0: scaled blue over corrected red
   logic             div_vld_ff [0:DIV_STAGES];
   logic             div_bad_ff [0:DIV_STAGES];
   logic [DEN_W-1:0] div_den_ff [0:DIV_STAGES];
   logic [DEN_W-1:0] div_rem_ff [0:DIV_STAGES];
   logic [NUM_W-1:0] div_nq_ff  [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else begin
         div_vld_ff[0] <= s3_vld_ff;
      end
      div_bad_ff[0] <= s3_bad_ff;
      div_den_ff[0] <= s3_red_ff;
      div_rem_ff[0] <= '0;
      div_nq_ff[0] <= NUM_W'(s3_blue_ff) * NUM_W'(CCT_COEF);
   end

   // divider stages, BITS_PER_STAGE quotient bits each
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      div_word_type step_in;

      always_comb begin
         step_in = {div_rem_ff[k], div_nq_ff[k]};
         for (int i = 0; i < BITS_PER_STAGE; i++) begin
            step_in = div_step(step_in, div_den_ff[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k+1] <= 1'b0;
         end else begin
            div_vld_ff[k+1] <= div_vld_ff[k];
         end
         div_bad_ff[k+1] <= div_bad_ff[k];
         div_den_ff[k+1] <= div_den_ff[k];
         div_rem_ff[k+1] <= step_in[DEN_W+NUM_W-1:NUM_W];
         div_nq_ff[k+1] <= step_in[NUM_W-1:0];
      end
   end

   // output register: offset, or zero for a rejected word
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] rsp_cct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_cct_ff <= '0;
      end else begin
         rsp_valid_ff <= div_vld_ff[DIV_STAGES];
         if (div_bad_ff[DIV_STAGES]) begin
            rsp_cct_ff <= '0;
         end else begin
            rsp_cct_ff <= div_nq_ff[DIV_STAGES][CNT_W-1:0] + CCT_OFFSET;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cct_kelvin = rsp_cct_ff;

   // checks
   `ASSERT_CLK(zero_den_flagged_a, clock, reset,
      (div_vld_ff[0] && div_den_ff[0] == '0) |-> div_bad_ff[0])
   `ASSERT_CLK(rem_below_den_a, clock, reset,
      (div_vld_ff[DIV_STAGES] && !div_bad_ff[DIV_STAGES])
      |-> (div_rem_ff[DIV_STAGES] < div_den_ff[DIV_STAGES]))
   `ASSERT_CLK(rsp_follows_req_a, clock, reset,
      rsp_valid_ff |-> $past(s1_vld_ff, DIV_STAGES + 4))

endmodule

@@ verif/color_temp_ir_ratio_test.sv @@
// Self-checking testbench for color_temp_ir_ratio: directed corner words, then random words
// under several sender idle rates and register settings, checked against a local predictor.
// Depends on ctir_pkg and the color_temp_ir_ratio RTL only.
module color_temp_ir_ratio_test
   import ctir_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CNT_W-1:0]      req_red_count;
   logic [CNT_W-1:0]      req_green_count;
   logic [CNT_W-1:0]      req_blue_count;
   logic [CNT_W-1:0]      req_clear_count;
   logic                  rsp_valid;
   logic [CNT_W-1:0]      rsp_cct_kelvin;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // one reading in flight with the kelvin value it should produce
   typedef struct {
      logic [CNT_W-1:0] red;
      logic [CNT_W-1:0] green;
      logic [CNT_W-1:0] blue;
      logic [CNT_W-1:0] clear;
      logic [CNT_W-1:0] kelvin;
   } cct_entry_type;

   cct_entry_type pending_cct[$];
   logic [7:0]  integ_code;
   logic        sensor_on;
   int unsigned mismatches;
   int unsigned cycle_count;

   color_temp_ir_ratio dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_red_count   (req_red_count),
      .req_green_count (req_green_count),
      .req_blue_count  (req_blue_count),
      .req_clear_count (req_clear_count),
      .rsp_valid       (rsp_valid),
      .rsp_cct_kelvin  (rsp_cct_kelvin),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_cct.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // clear level at or above which a reading counts as saturated
   function automatic int unsigned saturation_level(input logic [7:0] code);
      int unsigned steps;
      int unsigned level;
      steps = 256 - int'(code);
      if (steps > ANALOG_LIMIT) return DIGITAL_SAT;
      level = COUNTS_PER_STEP * steps;
      return level - level / 4;
   endfunction

   // expected kelvin for one reading under the current register values
   function automatic logic [CNT_W-1:0] predict_cct(input logic [CNT_W-1:0] r, g, b, c);
      logic [SUM_W-1:0] total;
      logic [CNT_W-1:0] ir;
      logic [CNT_W-1:0] red_adj;
      logic [CNT_W-1:0] blue_adj;
      int unsigned      scaled;
      if (!sensor_on) return '0;
      if (c == '0) return '0;
      if (int'(c) >= saturation_level(integ_code)) return '0;
      total = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      // IR is half the excess of r+g+b over clear, wrapped to 16 bits
      ir = (total > SUM_W'(c)) ? CNT_W'((total - SUM_W'(c)) >> 1) : '0;
      red_adj = r - ir;
      blue_adj = b - ir;
      if (red_adj == '0) return '0;
      scaled = int'(CCT_COEF) * int'(blue_adj);
      return CNT_W'(scaled / int'(red_adj) + int'(CCT_OFFSET));
   endfunction

   // result checker: every strobe must match the oldest pending word
   always @(posedge clock) begin
      cct_entry_type want;
      if (!reset && rsp_valid) begin
         if (pending_cct.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result cct_kelvin=%0d", rsp_cct_kelvin);
         end else begin
            want = pending_cct.pop_front();
            if (rsp_cct_kelvin !== want.kelvin) begin
               mismatches = mismatches + 1;
               if (mismatches <= MAX_REPORTS)
                  $display("cct_kelvin mismatch r=%0d g=%0d b=%0d c=%0d: expected %0d got %0d",
                           want.red, want.green, want.blue, want.clear,
                           want.kelvin, rsp_cct_kelvin);
            end
         end
      end
   end

   // drive one word and hold it until the block takes it
   task automatic send_reading(input logic [CNT_W-1:0] r, g, b, c);
      cct_entry_type entry;
      start <= 1'b1;
      req_red_count <= r;
      req_green_count <= g;
      req_blue_count <= b;
      req_clear_count <= c;
      do @(posedge clock); while (busy);
      entry.red = r;
      entry.green = g;
      entry.blue = b;
      entry.clear = c;
      entry.kelvin = predict_cct(r, g, b, c);
      pending_cct.push_back(entry);
   endtask

   // sender idles each cycle with the given percent chance
   task automatic idle_sender(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected result has arrived
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_cct.size() != 0) @(posedge clock);
   endtask

   // register write, only with the pipeline empty
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_INTEG_TIME) integ_code = data;
      else if (idx == CSR_SENSOR_READY) sensor_on = data[0];
   endtask

   // out of reset the sensor is not ready: every reading gives zero
   task automatic test_sensor_not_ready();
      send_reading(16'd1000, 16'd900, 16'd800, 16'd500);
      send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_reading(16'd0, 16'd0, 16'd0, 16'd0);
   endtask

   // zero clear and the saturation edge for several integration codes
   task automatic test_saturation_levels();
      write_csr(CSR_SENSOR_READY, 8'd1);
      // shortest integration: level 768
      send_reading(16'd300, 16'd200, 16'd100, 16'd0);
      send_reading(16'd300, 16'd200, 16'd100, 16'd767);
      send_reading(16'd300, 16'd200, 16'd100, 16'd768);
      send_reading(16'd300, 16'd200, 16'd100, 16'hFFFF);
      // longest integration: digital saturation
      write_csr(CSR_INTEG_TIME, 8'd0);
      send_reading(16'd30000, 16'd20000, 16'd10000, 16'd65534);
      send_reading(16'd30000, 16'd20000, 16'd10000, 16'hFFFF);
      // last code in the analog range, then the first past it
      write_csr(CSR_INTEG_TIME, 8'd193);
      send_reading(16'd20000, 16'd15000, 16'd10000, 16'd48383);
      send_reading(16'd20000, 16'd15000, 16'd10000, 16'd48384);
      write_csr(CSR_INTEG_TIME, 8'd192);
      send_reading(16'd20000, 16'd15000, 16'd10000, 16'd48384);
   endtask

   // IR estimate and corrected-channel corners
   task automatic test_ir_correction();
      write_csr(CSR_INTEG_TIME, 8'd0);
      // no excess over clear, and excess exactly zero
      send_reading(16'd10, 16'd10, 16'd10, 16'd40);
      send_reading(16'd10, 16'd10, 16'd10, 16'd30);
      // corrected red lands on zero
      send_reading(16'd100, 16'd100, 16'd100, 16'd100);
      // corrected blue wraps below zero
      send_reading(16'd1000, 16'd1000, 16'd0, 16'd200);
      // IR estimate past 16 bits wraps
      send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      // corrected red of one: result wraps to 16 bits
      send_reading(16'd3, 16'd0, 16'hFFFF, 16'hFFFE);
      // odd excess rounds down
      send_reading(16'd500, 16'd401, 16'd300, 16'd600);
   endtask

   // one random word, mostly well-formed for the current integration code
   task automatic send_random_reading();
      int unsigned level;
      int unsigned c;
      int unsigned g;
      int unsigned b;
      int unsigned lim;
      level = saturation_level(integ_code);
      case ($urandom_range(9))
         0, 1: begin
            send_reading(CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                         CNT_W'($urandom));
         end
         7: begin
            c = level - 1 + $urandom_range(2);
            if (c > DIGITAL_SAT) c = DIGITAL_SAT;
            send_reading(CNT_W'($urandom_range(c / 2)), CNT_W'($urandom_range(c / 2)),
                         CNT_W'($urandom_range(c / 2)), CNT_W'(c));
         end
         8: begin
            // red minus the IR estimate comes out exactly zero
            g = $urandom_range(1, 20000);
            b = $urandom_range(1, 20000);
            lim = (level - 1 < g + b - 1) ? level - 1 : g + b - 1;
            c = $urandom_range(1, lim);
            send_reading(CNT_W'(g + b - c), CNT_W'(g), CNT_W'(b), CNT_W'(c));
         end
         9: begin
            send_reading(CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                         CNT_W'($urandom_range(3)));
         end
         default: begin
            c = $urandom_range(1, level - 1);
            send_reading(CNT_W'($urandom_range(c / 2 + 1)), CNT_W'($urandom_range(c / 2 + 1)),
                         CNT_W'($urandom_range(c / 2 + 1)), CNT_W'(c));
         end
      endcase
   endtask

   // one phase of random words under fixed registers and idle rate
   task automatic run_random_phase(input int count, input int pct, input logic [7:0] code,
                                   input logic ready);
      write_csr(CSR_INTEG_TIME, code);
      write_csr(CSR_SENSOR_READY, {(CSR_DATA_W-1)'($urandom_range(127)), ready});
      for (int i = 0; i < count; i++) begin
         idle_sender(pct);
         send_random_reading();
      end
   endtask

   task automatic test_random_readings();
      run_random_phase(250, 0, 8'd255, 1'b1);
      run_random_phase(250, 70, 8'd0, 1'b1);
      run_random_phase(250, 26, 8'd193, 1'b1);
      run_random_phase(200, 0, 8'($urandom_range(193, 255)), 1'b1);
      run_random_phase(100, 70, 8'd192, 1'b0);
      run_random_phase(250, 26, 8'($urandom_range(255)), 1'b1);
      run_random_phase(200, 0, 8'($urandom_range(230, 255)), 1'b1);
   endtask

   initial begin
      mismatches = 0;
      cycle_count = 0;
      integ_code = INTEG_TIME_RESET;
      sensor_on = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_red_count <= '0;
      req_green_count <= '0;
      req_blue_count <= '0;
      req_clear_count <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sensor_not_ready();
      test_saturation_levels();
      test_ir_correction();
      test_random_readings();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_cct.size() != 0)
         $display("%0d expected results never arrived", pending_cct.size());
      if (mismatches == 0 && pending_cct.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
